FILE: hw/rtl/euler_to_quaternion_macros.svh
// Assertion macros used by the checker in e2q_checker.sv
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// Implication checked at every clock edge outside reset
`define E2Q_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent
`define E2Q_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Types and constants for the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

   // field widths of the angle and quaternion words
   localparam int AngleWidth  = 16;
   localparam int QuatWidth   = 16;

   localparam int CordicSteps = 17;
   // Q.16 half-angle bounds
   localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
   localparam logic signed [19:0] PiQ16     = 20'sd205887;
   // CORDIC gain, Q.30
   localparam logic signed [33:0] GainQ30   = 34'sd652032874;

   typedef struct packed {
      logic [AngleWidth-1:0] pitch_angle;
      logic [AngleWidth-1:0] yaw_angle;
      logic [AngleWidth-1:0] roll_angle;
   } req_word_type;

   typedef struct packed {
      logic [QuatWidth-1:0] quat_w;
      logic [QuatWidth-1:0] quat_x;
      logic [QuatWidth-1:0] quat_y;
      logic [QuatWidth-1:0] quat_z;
   } rsp_word_type;

   // Sine and cosine of one half angle, Q.16
   typedef struct packed {
      logic signed [17:0] cos_q16;
      logic signed [17:0] sin_q16;
   } sincos_type;

   function automatic logic signed [19:0] atan_q16(input logic [4:0] idx);
      logic signed [19:0] r;
      case (idx)
         5'd0:  r = 20'sd51472;
         5'd1:  r = 20'sd30386;
         5'd2:  r = 20'sd16055;
         5'd3:  r = 20'sd8150;
         5'd4:  r = 20'sd4091;
         5'd5:  r = 20'sd2047;
         5'd6:  r = 20'sd1024;
         5'd7:  r = 20'sd512;
         5'd8:  r = 20'sd256;
         5'd9:  r = 20'sd128;
         5'd10: r = 20'sd64;
         5'd11: r = 20'sd32;
         5'd12: r = 20'sd16;
         5'd13: r = 20'sd8;
         5'd14: r = 20'sd4;
         5'd15: r = 20'sd2;
         5'd16: r = 20'sd1;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/e2q_cordic.sv
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: sine and cosine of half an input angle,
// one CORDIC step per stage plus an entry and an exit stage.
// ----------------------------------------------------------------------------
module e2q_cordic #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [ANGLE_WIDTH-1:0]    angle,
   output e2q_pkg::sincos_type       result
);

   localparam int Steps = e2q_pkg::CordicSteps;
   localparam int Sh    = 19 - ANGLE_WIDTH;

   // half angle in Q.16, fits 20 bits at any width in range
   logic signed [19:0] half_in;
   logic signed [19:0] red_in;
   logic               flip_in;

   if (Sh >= 0) begin : g_scale_up
      assign half_in = {{(20-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle} <<< Sh;
   end else begin : g_scale_down
      logic signed [ANGLE_WIDTH-1:0] sh_a;
      assign sh_a    = $signed(angle) >>> (-Sh);
      assign half_in = sh_a[19:0];
   end

   always_comb begin
      flip_in = 1'b0;
      red_in  = half_in;
      if (half_in > e2q_pkg::HalfPiQ16) begin
         red_in  = half_in - e2q_pkg::PiQ16;
         flip_in = 1'b1;
      end else if (half_in < -e2q_pkg::HalfPiQ16) begin
         red_in  = half_in + e2q_pkg::PiQ16;
         flip_in = 1'b1;
      end
   end

   logic signed [33:0] x_ff [0:Steps];
   logic signed [33:0] y_ff [0:Steps];
   logic signed [19:0] z_ff [0:Steps];
   logic               f_ff [0:Steps];

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= e2q_pkg::GainQ30;
         y_ff[0] <= '0;
         z_ff[0] <= red_in;
         f_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      logic signed [33:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - e2q_pkg::atan_q16(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + e2q_pkg::atan_q16(5'(i));
            end
            f_ff[i+1] <= f_ff[i];
         end
      end
   end

   // round Q.30 to Q.16, negate on a reduced angle
   logic signed [33:0] cr, sr;
   logic signed [19:0] c20, s20;
   e2q_pkg::sincos_type out_ff;

   always_comb begin
      cr  = (x_ff[Steps] + 34'sd8192) >>> 14;
      sr  = (y_ff[Steps] + 34'sd8192) >>> 14;
      c20 = f_ff[Steps] ? -cr[19:0] : cr[19:0];
      s20 = f_ff[Steps] ? -sr[19:0] : sr[19:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.cos_q16 <= c20[17:0];
         out_ff.sin_q16 <= s20[17:0];
      end
   end

   assign result = out_ff;

endmodule

FILE: hw/rtl/e2q_mix.sv
// ----------------------------------------------------------------------------
// e2q_mix
// Mixed products of the three sine/cosine pairs, rounding and saturation
// to the quaternion format, in three register stages.
// ----------------------------------------------------------------------------
module e2q_mix #(
   parameter int QUAT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  advance,
   input  e2q_pkg::sincos_type   sc_x,
   input  e2q_pkg::sincos_type   sc_y,
   input  e2q_pkg::sincos_type   sc_z,
   output logic [QUAT_WIDTH-1:0] quat_w,
   output logic [QUAT_WIDTH-1:0] quat_x,
   output logic [QUAT_WIDTH-1:0] quat_y,
   output logic [QUAT_WIDTH-1:0] quat_z
);

   localparam int Fr = QUAT_WIDTH - 2;
   localparam int Sh = 48 - Fr;

   // stage 1: pair products, Q.32
   logic signed [35:0] cc_ff, ss_ff, cs_ff, sc_ff;
   logic signed [17:0] cx_ff, sx_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cc_ff <= sc_y.cos_q16 * sc_z.cos_q16;
         ss_ff <= sc_y.sin_q16 * sc_z.sin_q16;
         cs_ff <= sc_y.cos_q16 * sc_z.sin_q16;
         sc_ff <= sc_y.sin_q16 * sc_z.cos_q16;
         cx_ff <= sc_x.cos_q16;
         sx_ff <= sc_x.sin_q16;
      end
   end

   // stage 2: triple products, Q.48
   logic signed [53:0] p_ff [0:7];
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= cx_ff * cc_ff;
         p_ff[1] <= sx_ff * ss_ff;
         p_ff[2] <= sx_ff * cc_ff;
         p_ff[3] <= cx_ff * ss_ff;
         p_ff[4] <= cx_ff * sc_ff;
         p_ff[5] <= sx_ff * cs_ff;
         p_ff[6] <= cx_ff * cs_ff;
         p_ff[7] <= sx_ff * sc_ff;
      end
   end

   // stage 3: sums, rounding, clamp
   function automatic logic [QUAT_WIDTH-1:0] to_quat(input logic signed [54:0] v);
      logic signed [54:0] q;
      logic signed [54:0] one;
      one = 55'sd1 <<< Fr;
      q   = (v + (55'sd1 <<< (Sh - 1))) >>> Sh;
      if (q > one) q = one;
      if (q < -one) q = -one;
      return q[QUAT_WIDTH-1:0];
   endfunction

   logic [QUAT_WIDTH-1:0] w_ff, x_ff, y_ff, z_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         w_ff <= to_quat(55'(p_ff[0]) + 55'(p_ff[1]));
         x_ff <= to_quat(55'(p_ff[2]) - 55'(p_ff[3]));
         y_ff <= to_quat(55'(p_ff[4]) + 55'(p_ff[5]));
         z_ff <= to_quat(55'(p_ff[6]) - 55'(p_ff[7]));
      end
   end

   assign quat_w = w_ff;
   assign quat_x = x_ff;
   assign quat_y = y_ff;
   assign quat_z = z_ff;

endmodule

FILE: hw/rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angles (pitch, yaw, roll) to a unit quaternion, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  word
//  req      in         pitch_angle, yaw_angle, roll_angle
//  rsp      out        quat_w, quat_x, quat_y, quat_z
//
//  One word per cycle while rsp is not stalled; a word passes the entry stage,
//  17 CORDIC steps, the exit stage and three product stages.
//  Reset clears the valid bits only.
//  A stall on rsp freezes the whole pipe while a finished word waits;
//  req_stall follows rsp_stall in that case.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  e2q_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output e2q_pkg::rsp_word_type rsp_word
);

   localparam int Depth = e2q_pkg::CordicSteps + 5;

   logic             advance;
   logic [Depth-1:0] vld_ff, vld_in;

   assign advance   = !(vld_ff[Depth-1] && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   e2q_pkg::sincos_type scx, scy, scz;

   e2q_cordic #(.ANGLE_WIDTH(e2q_pkg::AngleWidth)) u_cx (
      .clock(clock), .advance(advance),
      .angle(req_word.pitch_angle), .result(scx));
   e2q_cordic #(.ANGLE_WIDTH(e2q_pkg::AngleWidth)) u_cy (
      .clock(clock), .advance(advance),
      .angle(req_word.yaw_angle), .result(scy));
   e2q_cordic #(.ANGLE_WIDTH(e2q_pkg::AngleWidth)) u_cz (
      .clock(clock), .advance(advance),
      .angle(req_word.roll_angle), .result(scz));

   logic [e2q_pkg::QuatWidth-1:0] qw, qx, qy, qz;

   e2q_mix #(.QUAT_WIDTH(e2q_pkg::QuatWidth)) u_mix (
      .clock(clock), .advance(advance),
      .sc_x(scx), .sc_y(scy), .sc_z(scz),
      .quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz));

   assign rsp_valid       = vld_ff[Depth-1];
   assign rsp_word.quat_w = qw;
   assign rsp_word.quat_x = qx;
   assign rsp_word.quat_y = qy;
   assign rsp_word.quat_z = qz;

endmodule

FILE: hw/rtl/e2q_checker.sv
// ----------------------------------------------------------------------------
// e2q_assertions
// Port-level checks for the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_macros.svh"

module e2q_assertions (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input e2q_pkg::rsp_word_type rsp_word
);

   // stalled result word holds
   `E2Q_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "rsp word changed under stall")
   // input stalls only while a finished word is stalled
   `E2Q_ASSERT_IMPL(a_req_stall, clock, reset, req_stall, rsp_valid && rsp_stall, "req stalled without cause")
   // quat_w stays within plus or minus one
   `E2Q_ASSERT_IMPL(a_w_range, clock, reset, rsp_valid, $signed(rsp_word.quat_w) <= 16'sd16384 && $signed(rsp_word.quat_w) >= -16'sd16384, "quat_w out of range")

endmodule

bind euler_to_quaternion e2q_assertions u_e2q_assertions (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word));
